/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the Euler path check unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLIES(name, clk, rst, pre, post)
`define ASSERT_NEXT(name, clk, rst, pre, post)

`endif

`endif

/* hw/rtl/eulc_pkg.sv */
// Shared types, constants and helper functions for the Euler path check unit.
package eulc_pkg;

   // Default node count, letter field width and balance width
   localparam int NODE_COUNT_DEF = 26;
   localparam int LETTER_W       = 5;
   localparam int BAL_W          = 18;

   typedef logic signed [BAL_W-1:0] bal_type;

   localparam bal_type BAL_MAX = {1'b0, {(BAL_W-1){1'b1}}};
   localparam bal_type BAL_MIN = {1'b1, {(BAL_W-1){1'b0}}};

   // Balance category of a used node
   typedef enum logic [1:0] {
      CAT_ZERO  = 2'd0,
      CAT_PLUS  = 2'd1,
      CAT_MINUS = 2'd2,
      CAT_BAD   = 2'd3
   } bal_cat_type;

   // Controls from the sequencer to the balance store
   typedef struct packed {
      logic rd;
      logic wr_src;
      logic wr_dst;
      logic clear;
   } bal_ctrl_type;

   // Status from the balance store
   typedef struct packed {
      logic newly_used;
      logic degrees_ok;
   } bal_sts_type;

   // Controls from the sequencer to the link store
   typedef struct packed {
      logic start;
      logic clear;
   } link_ctrl_type;

   // Status from the link store
   typedef struct packed {
      logic done;
      logic joined;
   } link_sts_type;

   // Classify a balance value
   function automatic bal_cat_type bal_cat(input bal_type v);
      bal_cat_type c;
      if (v == bal_type'(1))
         c = CAT_PLUS;
      else if (v == bal_type'(-1))
         c = CAT_MINUS;
      else if (v == bal_type'(0))
         c = CAT_ZERO;
      else
         c = CAT_BAD;
      return c;
   endfunction

   // Step a balance by one toward up or down, saturating at the limits
   function automatic bal_type bal_step(input bal_type v, input logic up);
      bal_type r;
      if (up)
         r = (v == BAL_MAX) ? v : v + bal_type'(1);
      else
         r = (v == BAL_MIN) ? v : v - bal_type'(1);
      return r;
   endfunction

endpackage

/* hw/rtl/euler_path_existence_check_unit.sv */
// Top level of the Euler path check unit: request sequencer, root count, verdict.
//
// Usage: each request on the req_ channel carries one directed edge of a case
// (req_first_letter -> req_final_letter, node indexes below NODE_COUNT) and
// req_last_edge, which marks the final edge of the case. A request is taken at
// a clock edge with req_valid high and req_stall low; req_stall is low only
// while the unit is idle, so one edge is in work at a time.
// Sequence: an in-range edge reads both balances when taken, writes the source
// balance (ST_BAL_A), writes the target balance and starts the root chase
// (ST_BAL_B), then waits in ST_CHASE while both sides follow parent links,
// one step per cycle on the dual read port. An edge with a letter at or above
// NODE_COUNT changes nothing. A last edge then enters the verdict step, which
// registers the verdict onto rsp_valid / rsp_ordering_possible once the output
// is free; it holds while rsp_stall is high. A later last edge waits there
// until the held response is taken; no further edges are accepted meanwhile.
// Reset (synchronous, active high) empties the graph at once: used and link
// flags and all counters clear, with no sweep of the memories.
// A verdict likewise clears the graph for the next case.
`include "assert_macros.svh"

module euler_path_existence_check_unit
   import eulc_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [LETTER_W-1:0] req_first_letter,
   input  logic [LETTER_W-1:0] req_final_letter,
   input  logic                req_last_edge,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_ordering_possible
);

   localparam int IDX_W = $clog2(NODE_COUNT);
   localparam int CNT_W = $clog2(NODE_COUNT + 1);
   localparam logic [LETTER_W:0] NODE_LIMIT = (LETTER_W+1)'(NODE_COUNT);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_BAL_A  = 5'b00010,
      ST_BAL_B  = 5'b00100,
      ST_CHASE  = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] src_ff, dst_ff;
   logic             last_ff;
   logic [CNT_W-1:0] roots_ff, roots_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ok_ff;

   logic             req_accept;
   logic             req_in_range;
   logic             rsp_free;
   logic             load_rsp;
   logic             verdict;
   bal_ctrl_type     bal_ctrl;
   bal_sts_type      bal_sts;
   link_ctrl_type    link_ctrl;
   link_sts_type     link_sts;

   // Accept a request only while idle
   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid & ~req_stall;
   assign req_in_range = ({1'b0, req_first_letter} < NODE_LIMIT) &&
                         ({1'b0, req_final_letter} < NODE_LIMIT);
   assign rsp_free     = ~rsp_valid_ff | ~rsp_stall;

   // Sequence one edge: balance source, balance target, chase roots, and on a last edge the verdict
   always_comb begin
      state_in  = state_ff;
      bal_ctrl  = '0;
      link_ctrl = '0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_in_range) begin
                  bal_ctrl.rd = 1'b1;
                  state_in    = ST_BAL_A;
               end else if (req_last_edge) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_BAL_A: begin
            bal_ctrl.wr_src = 1'b1;
            state_in        = ST_BAL_B;
         end
         ST_BAL_B: begin
            bal_ctrl.wr_dst = (src_ff != dst_ff);
            link_ctrl.start = 1'b1;
            state_in        = ST_CHASE;
         end
         ST_CHASE: begin
            if (link_sts.done) begin
               state_in = last_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               load_rsp        = 1'b1;
               bal_ctrl.clear  = 1'b1;
               link_ctrl.clear = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold the edge under work
   always_ff @(posedge clock) begin
      if (req_accept) begin
         src_ff  <= req_first_letter[IDX_W-1:0];
         dst_ff  <= req_final_letter[IDX_W-1:0];
         last_ff <= req_last_edge;
      end
   end

   // Count components: a newly used node adds one, a union removes one, a verdict clears the count
   always_comb begin
      roots_in = roots_ff;
      if (load_rsp)
         roots_in = '0;
      else if (bal_sts.newly_used)
         roots_in = roots_ff + CNT_W'(1);
      else if (link_sts.joined)
         roots_in = roots_ff - CNT_W'(1);
   end

   assign verdict = (roots_ff <= CNT_W'(1)) & bal_sts.degrees_ok;

   // Output register: load on verdict, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp)
         rsp_valid_in = 1'b1;
      else if (!rsp_stall)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ok_ff <= verdict;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         roots_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         roots_ff     <= roots_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_ordering_possible = rsp_ok_ff;

   eulc_bal_store #(
      .NODE_COUNT (NODE_COUNT)
   ) u_bal_store (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (bal_ctrl),
      .rd_src_idx (req_first_letter[IDX_W-1:0]),
      .rd_dst_idx (req_final_letter[IDX_W-1:0]),
      .src_idx    (src_ff),
      .dst_idx    (dst_ff),
      .sts        (bal_sts)
   );

   eulc_link_store #(
      .NODE_COUNT (NODE_COUNT)
   ) u_link_store (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (link_ctrl),
      .src_idx (src_ff),
      .dst_idx (dst_ff),
      .sts     (link_sts)
   );

   // A response only appears out of the verdict step
   `ASSERT_IMPLIES(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_FINISH))

   // The root chase only finishes while the sequencer waits for it
   `ASSERT_IMPLIES(a_chase_in_state, clock, reset, link_sts.done, state_ff == ST_CHASE)

   // The component count never exceeds the node count
   `ASSERT_IMPLIES(a_roots_bounded, clock, reset, 1'b1, roots_ff <= CNT_W'(NODE_COUNT))

   // An in-range edge goes straight to the balance update
   `ASSERT_NEXT(a_edge_to_bal, clock, reset, req_accept && req_in_range, state_ff == ST_BAL_A)

endmodule

/* hw/rtl/eulc_bal_store.sv */
// Balance memory with used flags and running balance category counts.
module eulc_bal_store
   import eulc_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  bal_ctrl_type                  ctrl,
   input  logic [$clog2(NODE_COUNT)-1:0] rd_src_idx,
   input  logic [$clog2(NODE_COUNT)-1:0] rd_dst_idx,
   input  logic [$clog2(NODE_COUNT)-1:0] src_idx,
   input  logic [$clog2(NODE_COUNT)-1:0] dst_idx,
   output bal_sts_type                   sts
);

   localparam int IDX_W = $clog2(NODE_COUNT);
   localparam int CNT_W = $clog2(NODE_COUNT + 1);

   bal_type                 bal_mem [NODE_COUNT];
   bal_type                 rd_src_ff;
   bal_type                 rd_dst_ff;
   logic [NODE_COUNT-1:0]   used_ff;
   logic [NODE_COUNT-1:0]   used_in;
   logic [CNT_W-1:0]        plus_ff, plus_in;
   logic [CNT_W-1:0]        minus_ff, minus_in;
   logic [CNT_W-1:0]        bad_ff, bad_in;

   logic                    wr;
   logic [IDX_W-1:0]        wr_idx;
   bal_type                 old_val;
   bal_type                 new_val;
   bal_cat_type             old_cat;
   bal_cat_type             new_cat;
   logic                    self_loop;

   // Read both endpoints of the edge; the registered data is valid from the next cycle
   always_ff @(posedge clock) begin
      if (ctrl.rd) begin
         rd_src_ff <= bal_mem[rd_src_idx];
         rd_dst_ff <= bal_mem[rd_dst_idx];
      end
   end

   // Pick the entry being written; an unused entry reads as zero
   assign wr        = ctrl.wr_src | ctrl.wr_dst;
   assign wr_idx    = ctrl.wr_src ? src_idx : dst_idx;
   assign self_loop = (src_idx == dst_idx);
   assign old_val   = !used_ff[wr_idx] ? '0 : (ctrl.wr_src ? rd_src_ff : rd_dst_ff);
   assign new_val   = (ctrl.wr_src && self_loop) ? old_val : bal_step(old_val, ctrl.wr_src);
   assign old_cat   = bal_cat(old_val);
   assign new_cat   = bal_cat(new_val);

   // Write back the updated balance
   always_ff @(posedge clock) begin
      if (wr) begin
         bal_mem[wr_idx] <= new_val;
      end
   end

   // Move the node between categories and mark it used
   always_comb begin
      used_in  = used_ff;
      plus_in  = plus_ff;
      minus_in = minus_ff;
      bad_in   = bad_ff;
      if (ctrl.clear) begin
         used_in  = '0;
         plus_in  = '0;
         minus_in = '0;
         bad_in   = '0;
      end else if (wr) begin
         used_in[wr_idx] = 1'b1;
         case (old_cat)
            CAT_PLUS:  plus_in  = plus_in  - CNT_W'(1);
            CAT_MINUS: minus_in = minus_in - CNT_W'(1);
            CAT_BAD:   bad_in   = bad_in   - CNT_W'(1);
            default:   ;
         endcase
         case (new_cat)
            CAT_PLUS:  plus_in  = plus_in  + CNT_W'(1);
            CAT_MINUS: minus_in = minus_in + CNT_W'(1);
            CAT_BAD:   bad_in   = bad_in   + CNT_W'(1);
            default:   ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= '0;
         plus_ff  <= '0;
         minus_ff <= '0;
         bad_ff   <= '0;
      end else begin
         used_ff  <= used_in;
         plus_ff  <= plus_in;
         minus_ff <= minus_in;
         bad_ff   <= bad_in;
      end
   end

   // Report first use and the degree condition
   assign sts.newly_used = wr & ~used_ff[wr_idx];
   assign sts.degrees_ok = (bad_ff == '0) &&
                           (((plus_ff == '0) && (minus_ff == '0)) ||
                            ((plus_ff == CNT_W'(1)) && (minus_ff == CNT_W'(1))));

endmodule

/* hw/rtl/eulc_link_store.sv */
// Parent-link memory with a two-sided root chase and the union write.
module eulc_link_store
   import eulc_pkg::*;
#(
   parameter int NODE_COUNT = NODE_COUNT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  link_ctrl_type                 ctrl,
   input  logic [$clog2(NODE_COUNT)-1:0] src_idx,
   input  logic [$clog2(NODE_COUNT)-1:0] dst_idx,
   output link_sts_type                  sts
);

   localparam int IDX_W = $clog2(NODE_COUNT);

   logic [IDX_W-1:0]      par_mem [NODE_COUNT];
   logic [NODE_COUNT-1:0] par_vld_ff;
   logic [NODE_COUNT-1:0] par_vld_in;
   logic                  busy_ff, busy_in;
   logic [IDX_W-1:0]      cur_a_ff, cur_b_ff;
   logic [IDX_W-1:0]      rd_a_ff, rd_b_ff;
   logic                  rd_a_vld_ff, rd_b_vld_ff;

   logic [IDX_W-1:0]      eff_a, eff_b;
   logic                  both_done;
   logic                  rd_en;
   logic [IDX_W-1:0]      addr_a, addr_b;
   logic                  join_wr;

   // A node never linked points to itself
   assign eff_a     = rd_a_vld_ff ? rd_a_ff : cur_a_ff;
   assign eff_b     = rd_b_vld_ff ? rd_b_ff : cur_b_ff;
   assign both_done = (eff_a == cur_a_ff) && (eff_b == cur_b_ff);

   // Issue the next step of the chase on both sides
   assign rd_en  = ctrl.start | (busy_ff & ~both_done);
   assign addr_a = ctrl.start ? src_idx : eff_a;
   assign addr_b = ctrl.start ? dst_idx : eff_b;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff     <= par_mem[addr_a];
         rd_b_ff     <= par_mem[addr_b];
         rd_a_vld_ff <= par_vld_ff[addr_a];
         rd_b_vld_ff <= par_vld_ff[addr_b];
         cur_a_ff    <= addr_a;
         cur_b_ff    <= addr_b;
      end
   end

   // Hang the target's root under the source's root
   assign join_wr = busy_ff & both_done & (cur_a_ff != cur_b_ff);

   always_ff @(posedge clock) begin
      if (join_wr) begin
         par_mem[cur_b_ff] <= cur_a_ff;
      end
   end

   always_comb begin
      par_vld_in = par_vld_ff;
      busy_in    = busy_ff;
      if (ctrl.clear) begin
         par_vld_in = '0;
      end else if (join_wr) begin
         par_vld_in[cur_b_ff] = 1'b1;
      end
      if (ctrl.start)
         busy_in = 1'b1;
      else if (busy_ff && both_done)
         busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         par_vld_ff <= '0;
         busy_ff    <= 1'b0;
      end else begin
         par_vld_ff <= par_vld_in;
         busy_ff    <= busy_in;
      end
   end

   assign sts.done   = busy_ff & both_done;
   assign sts.joined = join_wr;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the Euler path check unit: edge requests in, verdicts checked.
module testbench
   import eulc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES       = NODE_COUNT_DEF;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 64;
   localparam int REPORT_MAX  = 10;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [LETTER_W-1:0] req_first_letter;
   logic [LETTER_W-1:0] req_final_letter;
   logic                req_last_edge;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_ordering_possible;

   // Shadow graph that predicts the verdict of each case
   logic [LETTER_W-1:0] node_parent [NODES];
   bal_type             node_balance [NODES];
   bit                  node_seen [NODES];
   bit                  expected_verdicts [$];

   int  cycle_count      = 0;
   int  mismatch_count   = 0;
   int  edges_sent       = 0;
   int  cases_sent       = 0;
   int  verdicts_checked = 0;
   int  verdicts_true    = 0;
   int  stall_left       = 0;
   bit  no_idle          = 1'b0;

   euler_path_existence_check_unit u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_first_letter      (req_first_letter),
      .req_final_letter      (req_final_letter),
      .req_last_edge         (req_last_edge),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_ordering_possible (rsp_ordering_possible)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts outstanding",
                  cycle_count, expected_verdicts.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // Empty the shadow graph
   function automatic void clear_graph();
      for (int i = 0; i < NODES; i++) begin
         node_parent[i]  = LETTER_W'(i);
         node_balance[i] = '0;
         node_seen[i]    = 1'b0;
      end
   endfunction

   // Follow parent links up to the component root
   function automatic int find_root(input int n);
      int steps;
      int p;
      steps = 0;
      while (steps < NODES && int'(node_parent[n]) != n) begin
         p = int'(node_parent[n]);
         if (p >= NODES)
            break;
         n = p;
         steps++;
      end
      return n;
   endfunction

   // Move a balance by one, clamped at the balance limits
   function automatic void shift_balance(input int n, input int d);
      int v;
      v = int'(node_balance[n]) + d;
      if (v > int'(BAL_MAX))
         v = int'(BAL_MAX);
      if (v < int'(BAL_MIN))
         v = int'(BAL_MIN);
      node_balance[n] = bal_type'(v);
   endfunction

   // Decide whether the current graph has an Euler path
   function automatic bit euler_verdict();
      int  roots;
      int  plus;
      int  minus;
      bit  degrees_ok;
      roots      = 0;
      plus       = 0;
      minus      = 0;
      degrees_ok = 1'b1;
      for (int i = 0; i < NODES; i++) begin
         if (node_seen[i]) begin
            if (int'(node_parent[i]) == i)
               roots++;
            if (node_balance[i] == bal_type'(1))
               plus++;
            else if (node_balance[i] == bal_type'(-1))
               minus++;
            else if (node_balance[i] != bal_type'(0))
               degrees_ok = 1'b0;
         end
      end
      if (roots > 1 || !degrees_ok)
         return 1'b0;
      return (plus == 0 && minus == 0) || (plus == 1 && minus == 1);
   endfunction

   // Apply one accepted edge to the shadow graph; queue a verdict on the last edge
   function automatic void record_edge(input int src, input int dst, input bit last);
      int ra;
      int rb;
      if (src < NODES && dst < NODES) begin
         node_seen[src] = 1'b1;
         node_seen[dst] = 1'b1;
         if (src != dst) begin
            shift_balance(src, 1);
            shift_balance(dst, -1);
         end
         ra = find_root(src);
         rb = find_root(dst);
         if (ra != rb)
            node_parent[rb] = LETTER_W'(ra);
      end
      if (last) begin
         expected_verdicts.push_back(euler_verdict());
         clear_graph();
      end
   endfunction

   // Pick an idle gap: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Stall the verdict channel in bursts
   always @(posedge clock) begin
      if (no_idle) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         stall_left--;
      end else begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               rsp_stall  <= 1'b0;
               stall_left = $urandom_range(0, 6);
            end
            9: begin
               rsp_stall  <= 1'b1;
               stall_left = $urandom_range(15, 60);
            end
            default: begin
               rsp_stall  <= 1'b1;
               stall_left = $urandom_range(0, 3);
            end
         endcase
      end
   end

   // Check each accepted verdict against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("verdict %0d arrived with none outstanding",
                        rsp_ordering_possible);
         end else begin
            bit want;
            want = expected_verdicts.pop_front();
            verdicts_checked++;
            if (want)
               verdicts_true++;
            if (rsp_ordering_possible !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("verdict mismatch on case %0d: expected %0d, got %0b",
                           verdicts_checked, want, rsp_ordering_possible);
            end
         end
      end
   end

   // Send one edge request and hold it until it is taken
   task automatic send_edge(input int src, input int dst, input bit last);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_first_letter <= LETTER_W'(src);
      req_final_letter <= LETTER_W'(dst);
      req_last_edge    <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      record_edge(src, dst, last);
      edges_sent++;
   endtask

   // Send a whole case; the final edge carries the last mark
   task automatic send_case(input int srcs[$], input int dsts[$]);
      for (int i = 0; i < srcs.size(); i++)
         send_edge(srcs[i], dsts[i], i == srcs.size() - 1);
      cases_sent++;
   endtask

   // Hold off new requests until every verdict has come back
   task automatic wait_for_verdicts();
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0)
         @(posedge clock);
   endtask

   // Extremes of the letters, ignored letters, loops, splits and bad balances
   task automatic test_directed_cases();
      send_case('{0},  '{25});
      send_case('{25}, '{25});
      send_case('{31}, '{31});
      send_case('{26}, '{0});
      send_case('{5},  '{27});
      send_case('{0, 30, 1}, '{1, 2, 2});
      send_case('{0, 2}, '{1, 3});
      send_case('{0, 0}, '{1, 2});
      send_case('{0, 1, 2}, '{1, 2, 0});
      send_case('{12, 13, 12}, '{13, 12, 13});
   endtask

   // Random cases: mostly trails, some broken ones, noise and deep chains
   task automatic test_random_cases(input int edge_budget);
      int srcs[$];
      int dsts[$];
      int start;
      int kind;
      int len;
      int base;
      int pool;
      int cur;
      int nxt;
      int pos;
      int top;
      start = edges_sent;
      while (edges_sent - start < edge_budget) begin
         srcs.delete();
         dsts.delete();
         kind = $urandom_range(0, 99);
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
         if (kind < 80) begin
            // walk a trail inside a random pool of nodes
            base = $urandom_range(0, NODES - 1);
            pool = $urandom_range(2, NODES);
            cur  = (base + $urandom_range(0, pool - 1)) % NODES;
            repeat (len) begin
               nxt = (base + $urandom_range(0, pool - 1)) % NODES;
               srcs.push_back(cur);
               dsts.push_back(nxt);
               cur = nxt;
            end
            // break some trails with one stray edge
            if (kind >= 60) begin
               pos = $urandom_range(0, srcs.size());
               srcs.insert(pos, $urandom_range(0, 31));
               dsts.insert(pos, $urandom_range(0, 31));
            end
         end else if (kind < 93) begin
            // arbitrary edges, a few with letters past the last node
            repeat (len) begin
               srcs.push_back(($urandom_range(0, 7) == 0) ?
                              $urandom_range(NODES, 31) : $urandom_range(0, NODES - 1));
               dsts.push_back(($urandom_range(0, 7) == 0) ?
                              $urandom_range(NODES, 31) : $urandom_range(0, NODES - 1));
            end
         end else begin
            // build a deep parent chain, then close it from its far end
            top = $urandom_range(1, NODES - 1);
            for (int k = top; k > 0; k--) begin
               srcs.push_back(k - 1);
               dsts.push_back(k);
            end
            srcs.push_back(top);
            dsts.push_back(0);
         end
         send_case(srcs, dsts);
      end
   endtask

   // Random cases with no gaps and no stalls
   task automatic test_back_to_back(input int edge_budget);
      no_idle = 1'b1;
      test_random_cases(edge_budget);
      no_idle = 1'b0;
   endtask

   initial begin
      clear_graph();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_first_letter <= '0;
      req_final_letter <= '0;
      req_last_edge    <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_cases();
      wait_for_verdicts();
      test_random_cases(550);
      wait_for_verdicts();
      test_back_to_back(150);
      test_random_cases(180);
      wait_for_verdicts();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d edge requests in %0d cases over %0d cycles",
               edges_sent, cases_sent, cycle_count);
      $display("checked %0d verdicts: %0d with a path, %0d without, %0d unanswered",
               verdicts_checked, verdicts_true, verdicts_checked - verdicts_true,
               expected_verdicts.size());
      if (mismatch_count == 0 && expected_verdicts.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

/* euler_path_existence_check_unit.f */
+incdir+hw/rtl
hw/rtl/eulc_pkg.sv
hw/rtl/eulc_bal_store.sv
hw/rtl/eulc_link_store.sv
hw/rtl/euler_path_existence_check_unit.sv
tb/testbench.sv
